FILE: rtl/core/sa_pkg.sv
// Shared types and constants for the stack allocator with padding header.
// No dependencies; imported by sa_ctrl, sa_dp and stack_allocator_with_header.
package sa_pkg;

  localparam int unsigned OFF_W  = 13;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ALOG_W = 4;

  localparam logic [OFF_W-1:0] LEN_RESET = 13'd4096;

  // Configuration register indexes
  localparam logic CFG_BASE_ADDRESS  = 1'b0;
  localparam logic CFG_BUFFER_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } sa_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BOUNDS  = 2'd2,
    ST_IGNORED = 2'd3
  } sa_status_e;

  typedef struct packed {
    sa_op_e              opcode;
    logic [OFF_W-1:0]    size;
    logic [ALOG_W-1:0]   align_log2;
    logic [ADDR_W-1:0]   address;
  } sa_req_t;

  typedef struct packed {
    sa_status_e          status;
    logic [ADDR_W-1:0]   result_address;
    logic [OFF_W-1:0]    top_offset;
  } sa_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FREE
  } sa_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic clr;   // write zero to header store at clear counter
    logic load;  // capture request
    logic exec;  // evaluate captured request
    logic fin;   // finish a free with the header byte just read
  } sa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;  // clear counter at last entry
    logic rd_pend;   // captured request needs a header read
  } sa_sts_t;

endpackage

FILE: rtl/core/sa_ctrl.sv
// Sequencer for the stack allocator: clearing pass, accept, evaluate, header read.
// Depends on sa_pkg.
module sa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sa_pkg::sa_sts_t sts_i,
  output sa_pkg::sa_cmd_t cmd_o,
  output logic            busy_o
);
  import sa_pkg::*;

  sa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.rd_pend ? S_FREE : S_IDLE;
      end
      S_FREE: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  a_free_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE |-> $past(state_q) == S_EXEC && $past(sts_i.rd_pend))
    else $error("free stage entered without a pending header read");

endmodule

FILE: rtl/core/sa_dp.sv
// Datapath of the stack allocator: config registers, stack top, header store,
// padding and bounds logic, result register. Depends on sa_pkg.
module sa_dp #(
  parameter int unsigned BUF_LEN        = 4096,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  sa_pkg::sa_req_t req_i,
  input  sa_pkg::sa_cmd_t cmd_i,
  output sa_pkg::sa_sts_t sts_o,
  output sa_pkg::sa_rsp_t rsp_o,
  output logic            done_o
);
  import sa_pkg::*;

  localparam int unsigned AW = $clog2(BUF_LEN);

  // Control / config state
  logic [ADDR_W-1:0] base_q;
  logic [OFF_W-1:0]  len_q;
  logic [OFF_W-1:0]  top_q, top_d;
  logic [AW-1:0]     clr_cnt_q;
  logic              done_q, done_d;

  // Payload
  sa_req_t           req_q;
  logic [OFF_W-1:0]  off_q;
  sa_rsp_t           rsp_q, rsp_d;

  // Header store
  logic [7:0]        mem [BUF_LEN];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  // Evaluation
  logic [OFF_W-1:0]  len_eff;
  logic [2:0]        alog_c;
  logic [7:0]        align_sz;
  logic [7:0]        mis;
  logic [7:0]        pad;
  logic [ADDR_W-1:0] top_addr;
  logic [OFF_W+1:0]  need;
  logic              oom;
  logic [OFF_W-1:0]  at;
  logic [ADDR_W-1:0] off_full;
  logic              oob;
  logic [OFF_W-1:0]  off;

  // Lengths above the buffer size act as the buffer size
  assign len_eff = ({19'd0, len_q} > 32'(BUF_LEN)) ? OFF_W'(BUF_LEN) : len_q;

  // Alignment padding; always leaves room for the one-byte header
  assign alog_c   = ({28'd0, req_q.align_log2} > 32'(MAX_ALIGN_LOG2)) ?
                    3'(MAX_ALIGN_LOG2) : req_q.align_log2[2:0];
  assign align_sz = 8'd1 << alog_c;
  assign top_addr = base_q + {19'd0, top_q};
  assign mis      = top_addr[7:0] & (align_sz - 8'd1);
  assign pad      = (mis != 8'd0) ? (align_sz - mis) : align_sz;
  assign need     = {2'd0, top_q} + {7'd0, pad} + {2'd0, req_q.size};
  assign oom      = need > {2'd0, len_eff};
  assign at       = top_q + {5'd0, pad};

  // Free bounds
  assign off_full = req_q.address - base_q;
  assign oob      = (req_q.address < base_q) || (off_full >= {19'd0, len_eff});
  assign off      = off_full[OFF_W-1:0];

  assign sts_o.rd_pend  = (req_q.opcode == OP_FREE) && (req_q.address != '0) && !oob &&
                          (off < top_q) && (off != '0);
  assign sts_o.clr_last = (clr_cnt_q == AW'(BUF_LEN - 1));

  assign mem_re = cmd_i.exec && sts_o.rd_pend;
  assign mem_ra = AW'(off - 13'd1);

  always_comb begin
    top_d  = top_q;
    done_d = 1'b0;
    mem_we = 1'b0;
    mem_wa = clr_cnt_q;
    mem_wd = 8'd0;
    rsp_d  = '{status: ST_IGNORED, result_address: '0, top_offset: top_q};

    if (cmd_i.clr) begin
      mem_we = 1'b1;
    end

    if (cmd_i.exec) begin
      done_d = !sts_o.rd_pend;
      unique case (req_q.opcode)
        OP_ALLOC: begin
          if (oom) begin
            rsp_d.status = ST_OOM;
          end else begin
            rsp_d.status         = ST_OK;
            rsp_d.result_address = top_addr + {24'd0, pad};
            top_d                = at + req_q.size;
            mem_we               = 1'b1;
            mem_wa               = AW'(at - 13'd1);
            mem_wd               = pad;
          end
        end
        OP_FREE: begin
          priority if (req_q.address == '0) begin
            rsp_d.status = ST_IGNORED;
          end else if (oob) begin
            rsp_d.status = ST_BOUNDS;
          end else if (off >= top_q) begin
            rsp_d.status = ST_IGNORED;   // double free
          end else if (off == '0) begin
            rsp_d.status = ST_BOUNDS;    // header would sit before the buffer
          end else begin
            rsp_d.status = ST_IGNORED;   // header read pending
          end
        end
        OP_FREE_ALL: begin
          rsp_d.status = ST_OK;
          top_d        = '0;
        end
        default: begin
          rsp_d.status = ST_IGNORED;
        end
      endcase
    end

    if (cmd_i.fin) begin
      done_d = 1'b1;
      if ({5'd0, rd_q} > off_q) begin
        rsp_d.status = ST_BOUNDS;        // corrupt or foreign header
      end else begin
        rsp_d.status = ST_OK;
        top_d        = off_q - {5'd0, rd_q};
      end
    end

    rsp_d.top_offset = top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      len_q     <= LEN_RESET;
      top_q     <= '0;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE_ADDRESS:  base_q <= cfg_data_i;
          CFG_BUFFER_LENGTH: len_q  <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      top_q  <= top_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      off_q <= off;
    end
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  a_rsp_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_q.top_offset == top_q)
    else $error("reported top offset differs from stack top");

  a_fail_keeps_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.status != ST_OK |-> top_q == $past(top_q))
    else $error("stack top moved on a failed request");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.status != ST_OK |-> rsp_q.result_address == '0)
    else $error("nonzero address on a failed request");

endmodule

FILE: rtl/core/stack_allocator_with_header.sv
// Top level of the stack allocator with one-byte padding header.
// Depends on sa_pkg, sa_ctrl and sa_dp.
//
// Stack allocator over a buffer of up to BUF_LEN bytes at base address
// cfg register 0, usable length cfg register 1. A request is taken at a rising
// edge with start_i high and busy_o low; start_i while busy_o is high is not a
// request. Every request yields exactly one response, shown on rsp_o for one
// cycle with done_o high; there is no back-pressure, so the receiver must take
// it then. Allocate, free-all, and frees rejected by the null, bounds or
// double-free checks are decided in the evaluate state and their response
// is registered; busy_o is low again in the strobe cycle, so a new request
// can be accepted at its end. A free that reaches the header store passes
// through the free state for the registered read of its header byte. After
// reset a clearing pass zeroes the header store, one byte per cycle, with
// busy_o high throughout; configuration writes are taken at any time, but
// should be made only while no request is in flight.
module stack_allocator_with_header #(
  parameter int unsigned BUF_LEN        = 4096,
  parameter int unsigned MAX_ALIGN_LOG2 = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  // request
  input  logic            start_i,
  input  sa_pkg::sa_req_t req_i,
  output logic            busy_o,
  // response
  output logic            done_o,
  output sa_pkg::sa_rsp_t rsp_o
);
  import sa_pkg::*;

  sa_cmd_t cmd;
  sa_sts_t sts;

  // Sequencer: clearing pass, accept, evaluate, optional header read
  sa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Datapath: stack top, header store, padding and bounds logic
  sa_dp #(
    .BUF_LEN        (BUF_LEN),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o),
    .done_o     (done_o)
  );

endmodule
